### rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk and switched off while rst_n is low.
`define CRCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion sampled on clk that also holds through reset.
`define CRCW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/crcw_pkg.sv
// Package of the word-wise CRC-32 engine: widths, types, tables and CRC functions.
`default_nettype none
package crcw_pkg;

  localparam int COUNT_BITS = 24;
  localparam int CNT_W      = COUNT_BITS;
  localparam int CFG_W      = 24;
  localparam int DATA_W     = 32;
  localparam int VB_W       = 3;
  localparam int BYTES      = DATA_W / 8;
  localparam int CFG_AW     = 3;
  localparam int APB_DW     = 32;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [DATA_W-1:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [DATA_W-1:0] PAD_WORD = 32'hFFFFFFFF;
  localparam logic [7:0]        FILL_BYTE = 8'd255;

  localparam logic [CFG_AW-3:0] REG_TOTAL_WORDS = '0;

  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic              feed;
    logic              last;
    logic              ovf;
    logic [CNT_W-1:0]  pad;
  } crcw_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } crcw_qstat_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_PAD,
    ST_EMIT
  } crcw_state_t;

  function automatic logic [DATA_W-1:0] nib_table(input logic [3:0] idx);
    logic [DATA_W-1:0] v;
    unique case (idx)
      4'h0: v = 32'h00000000;
      4'h1: v = 32'h04C11DB7;
      4'h2: v = 32'h09823B6E;
      4'h3: v = 32'h0D4326D9;
      4'h4: v = 32'h130476DC;
      4'h5: v = 32'h17C56B6B;
      4'h6: v = 32'h1A864DB2;
      4'h7: v = 32'h1E475005;
      4'h8: v = 32'h2608EDB8;
      4'h9: v = 32'h22C9F00F;
      4'hA: v = 32'h2F8AD6D6;
      4'hB: v = 32'h2B4BCB61;
      4'hC: v = 32'h350C9B64;
      4'hD: v = 32'h31CD86D3;
      4'hE: v = 32'h3C8EA00A;
      4'hF: v = 32'h384FBDBD;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] crc_word(input logic [DATA_W-1:0] crc,
                                                 input logic [DATA_W-1:0] w);
    logic [DATA_W-1:0] c;
    c = crc ^ w;
    for (int i = 0; i < 8; i++) begin
      c = {c[DATA_W-5:0], 4'h0} ^ nib_table(c[DATA_W-1:DATA_W-4]);
    end
    return c;
  endfunction

  function automatic logic [CNT_W-1:0] word_limit(input logic [CFG_W-1:0] t);
    logic [CFG_W+CNT_W-1:0] t_w;
    logic [CFG_W+CNT_W-1:0] m_w;
    t_w = (CFG_W + CNT_W)'(t);
    m_w = (CFG_W + CNT_W)'({CNT_W{1'b1}});
    return (t_w > m_w) ? CNT_W'(m_w) : CNT_W'(t_w);
  endfunction

endpackage
`default_nettype wire

### rtl/crcw_front.sv
// Front end: accepts image words, fills missing bytes and classifies each item.
`default_nettype none
module crcw_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [crcw_pkg::DATA_W-1:0] in_data_word,
  input  wire logic [crcw_pkg::VB_W-1:0]   in_valid_bytes,
  input  wire logic                       in_last,
  input  wire logic [crcw_pkg::CNT_W-1:0]  limit,
  input  wire crcw_pkg::crcw_qstat_t       qstat,
  output logic                            push,
  output crcw_pkg::crcw_entry_t           push_entry
);
  import crcw_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             feed;
  logic [CNT_W-1:0] cnt_after;
  logic [DATA_W-1:0] filled;

  always_comb begin
    for (int i = 0; i < BYTES; i++) begin
      filled[i*8 +: 8] = (in_valid_bytes > VB_W'(i)) ? in_data_word[i*8 +: 8] : FILL_BYTE;
    end
  end

  assign in_ready  = !qstat.full;
  assign push      = in_valid && in_ready;
  assign feed      = cnt_r < limit;
  assign cnt_after = feed ? cnt_r + 1'b1 : cnt_r;

  // A count already beyond the limit, after the size shrank mid-image, needs no padding.
  always_comb begin
    push_entry.word = filled;
    push_entry.feed = feed;
    push_entry.last = in_last;
    push_entry.ovf  = ovf_r || !feed;
    push_entry.pad  = (cnt_after < limit) ? limit - cnt_after : '0;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (push) begin
      if (in_last) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_after;
        ovf_nxt = ovf_r || !feed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/crcw_queue.sv
// Short queue of classified items between the front end and the CRC back end.
`default_nettype none
module crcw_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire crcw_pkg::crcw_entry_t push_entry,
  input  wire logic                  pop,
  output crcw_pkg::crcw_entry_t      pop_entry,
  output crcw_pkg::crcw_qstat_t      qstat
);
  import crcw_pkg::*;

  crcw_entry_t       slot_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign qstat.full  = cnt_r == QCNT_W'(QDEPTH);
  assign qstat.empty = cnt_r == '0;
  assign pop_entry   = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/crcw_back.sv
// Back end: folds queued words into the CRC, pads the partition and holds the result.
`default_nettype none
module crcw_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire crcw_pkg::crcw_qstat_t  qstat,
  output logic                        pop,
  input  wire crcw_pkg::crcw_entry_t  pop_entry,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [crcw_pkg::DATA_W-1:0] out_crc_value,
  output logic                        out_too_long
);
  import crcw_pkg::*;

  crcw_state_t       state_r, state_nxt;
  logic [DATA_W-1:0] crc_r, crc_nxt;
  logic [CNT_W-1:0]  pad_r, pad_nxt;
  logic              ovf_r, ovf_nxt;
  logic              ov_r, ov_nxt;
  logic [DATA_W-1:0] ocrc_r, ocrc_nxt;
  logic              otl_r, otl_nxt;
  logic              slot_free;

  assign slot_free     = !ov_r || out_ready;
  assign out_valid     = ov_r;
  assign out_crc_value = ocrc_r;
  assign out_too_long  = otl_r;

  always_comb begin
    state_nxt = state_r;
    crc_nxt   = crc_r;
    pad_nxt   = pad_r;
    ovf_nxt   = ovf_r;
    ocrc_nxt  = ocrc_r;
    otl_nxt   = otl_r;
    ov_nxt    = ov_r && !out_ready;
    pop       = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        if (!qstat.empty) begin
          pop = 1'b1;
          if (pop_entry.feed) begin
            crc_nxt = crc_word(crc_r, pop_entry.word);
          end
          if (pop_entry.last) begin
            pad_nxt   = pop_entry.pad;
            ovf_nxt   = pop_entry.ovf;
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (pad_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          crc_nxt = crc_word(crc_r, PAD_WORD);
          pad_nxt = pad_r - 1'b1;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ocrc_nxt  = crc_r;
          otl_nxt   = ovf_r;
          crc_nxt   = CRC_INIT;
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      crc_r   <= CRC_INIT;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      crc_r   <= crc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pad_r  <= pad_nxt;
    ovf_r  <= ovf_nxt;
    ocrc_r <= ocrc_nxt;
    otl_r  <= otl_nxt;
  end

endmodule
`default_nettype wire

### rtl/crc32_word_padded_image.sv
// Top level of the word-wise CRC-32 engine for padded firmware images.
//
//   Channel | Direction | Handshake            | Payload
//   in_     | input     | in_valid / in_ready  | data_word, valid_bytes, last
//   out_    | output    | out_valid / out_ready| crc_value, too_long
//   cfg_    | APB write | psel, penable, pwrite| total_words at byte address 0
//
// The back end folds one word per cycle while in ST_RUN with the queue not empty; after
// the last item it passes through ST_PAD and ST_EMIT to finish and load the result.
// Padding words are generated one per cycle in ST_PAD, and each surplus item is popped without being folded.
// A four-entry queue lets the front end accept up to four items while the back
// end pads or waits for out_ready. Synchronous reset clears all control state.
`default_nettype none
module crc32_word_padded_image (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [crcw_pkg::DATA_W-1:0] in_data_word,
  input  wire logic [crcw_pkg::VB_W-1:0]   in_valid_bytes,
  input  wire logic                        in_last,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [crcw_pkg::DATA_W-1:0]      out_crc_value,
  output logic                             out_too_long,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [crcw_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [crcw_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [crcw_pkg::APB_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready
);
  import crcw_pkg::*;

  logic [CFG_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] limit;
  logic             cfg_hit;
  crcw_qstat_t      qstat;
  crcw_entry_t      push_entry;
  crcw_entry_t      pop_entry;
  logic             push;
  logic             pop;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr[CFG_AW-1:2] == REG_TOTAL_WORDS;
  assign cfg_prdata = cfg_hit ? APB_DW'(total_r) : '0;
  assign limit      = word_limit(total_r);

  always_comb begin
    total_nxt = total_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      total_nxt = cfg_pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  crcw_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_word   (in_data_word),
    .in_valid_bytes (in_valid_bytes),
    .in_last        (in_last),
    .limit          (limit),
    .qstat          (qstat),
    .push           (push),
    .push_entry     (push_entry)
  );

  crcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .qstat      (qstat)
  );

  crcw_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .qstat         (qstat),
    .pop           (pop),
    .pop_entry     (pop_entry),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_crc_value (out_crc_value),
    .out_too_long  (out_too_long)
  );

endmodule
`default_nettype wire

### rtl/crcw_checker.sv
// Port-level checker of the CRC-32 engine and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module crcw_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_crc_value,
  input wire logic        out_too_long,
  input wire logic        cfg_psel,
  input wire logic        cfg_penable,
  input wire logic        cfg_pwrite,
  input wire logic [2:0]  cfg_paddr,
  input wire logic [31:0] cfg_pwdata,
  input wire logic [31:0] cfg_prdata,
  input wire logic        cfg_pready
);

  `CRCW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_crc_value) && $stable(out_too_long), "result item changed while stalled")
  `CRCW_ASSERT_RST(a_rst_clear, !rst_n |=> !out_valid, "result valid after reset")
  `CRCW_ASSERT_RST(a_pready, cfg_pready, "configuration port not ready")
  `CRCW_ASSERT(a_readback, (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) ##1 !cfg_paddr[2] |-> cfg_prdata == {8'h00, $past(cfg_pwdata[23:0])}, "partition size readback mismatch")

endmodule

bind crc32_word_padded_image crcw_checker u_crcw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_crc_value (out_crc_value),
  .out_too_long  (out_too_long),
  .cfg_psel      (cfg_psel),
  .cfg_penable   (cfg_penable),
  .cfg_pwrite    (cfg_pwrite),
  .cfg_paddr     (cfg_paddr),
  .cfg_pwdata    (cfg_pwdata),
  .cfg_prdata    (cfg_prdata),
  .cfg_pready    (cfg_pready)
);
`default_nettype wire

### tb/crc32_word_padded_image_tb.sv
// Self-checking testbench for the word-wise CRC-32 engine over padded firmware images.
module crc32_word_padded_image_tb;

  localparam int ITEM_TARGET    = 850;
  localparam int GAP_MAX        = 17;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_CYCLES   = 32;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int BIG_TOTAL      = 1000;
  localparam int SMALL_FIT      = 12;

  localparam logic [31:0]                  CRC_POLY  = 32'h04C11DB7;
  localparam logic [crcw_pkg::CNT_W-1:0]   COUNT_MAX = '1;
  localparam logic [crcw_pkg::CFG_W-1:0]   TOTAL_MAX = '1;
  localparam logic [crcw_pkg::CFG_AW-1:0]  TOTAL_WORDS_ADDR = {crcw_pkg::REG_TOTAL_WORDS, 2'b00};

  typedef enum logic {
    ROW_ITEM,
    ROW_CONFIG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] value;
    logic [2:0]  vb;
    logic        last;
    logic        typed;
    logic [31:0] want_crc;
    logic        want_ovf;
  } script_row_t;

  typedef struct packed {
    logic [31:0] crc;
    logic        too_long;
  } crc_result_t;

  localparam int SCRIPT_LEN = 26;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{ROW_ITEM,   32'hFFFFFFFF, 3'd4, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'h12345678, 3'd0, 1'b1, 1'b1, 32'hFFFFFFFF, 1'b1},
    '{ROW_CONFIG, 32'd1,        3'd0, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'h00000000, 3'd4, 1'b1, 1'b0, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'hFFFFFFFF, 3'd4, 1'b1, 1'b1, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'h12345678, 3'd0, 1'b1, 1'b1, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'h000000A5, 3'd1, 1'b1, 1'b0, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'hFFFF3C5A, 3'd2, 1'b1, 1'b0, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'h00800001, 3'd3, 1'b1, 1'b0, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'h89ABCDEF, 3'd5, 1'b1, 1'b0, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'h76543210, 3'd6, 1'b1, 1'b0, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'h80000000, 3'd7, 1'b1, 1'b0, 32'h00000000, 1'b0},
    '{ROW_CONFIG, 32'd3,        3'd0, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'hDEADBEEF, 3'd4, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'h00000000, 3'd4, 1'b1, 1'b0, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'h11111111, 3'd4, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'h22222222, 3'd4, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'h33333333, 3'd4, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'h44444444, 3'd4, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'h55555555, 3'd4, 1'b1, 1'b0, 32'h00000000, 1'b0},
    '{ROW_CONFIG, {8'h00, TOTAL_MAX}, 3'd0, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'hA5A5A5A5, 3'd4, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'h5A5A5A5A, 3'd4, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'hC0FFEE00, 3'd4, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{ROW_CONFIG, 32'd2,        3'd0, 1'b0, 1'b0, 32'h00000000, 1'b0},
    '{ROW_ITEM,   32'h0F0F0F0F, 3'd4, 1'b1, 1'b0, 32'h00000000, 1'b0}
  };

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [crcw_pkg::DATA_W-1:0]     in_data_word;
  logic [crcw_pkg::VB_W-1:0]       in_valid_bytes;
  logic                            in_last;
  logic                            out_valid;
  logic                            out_ready;
  logic [crcw_pkg::DATA_W-1:0]     out_crc_value;
  logic                            out_too_long;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [crcw_pkg::CFG_AW-1:0]     cfg_paddr;
  logic [crcw_pkg::APB_DW-1:0]     cfg_pwdata;
  logic [crcw_pkg::APB_DW-1:0]     cfg_prdata;
  logic                            cfg_pready;

  logic [31:0]                     crc_acc         = crcw_pkg::CRC_INIT;
  logic [crcw_pkg::CNT_W-1:0]      words_folded    = '0;
  logic                            overflow_flag   = 1'b0;
  logic [crcw_pkg::CFG_W-1:0]      total_words_cfg = '0;
  crc_result_t                     pending_crcs[$];

  int fail_count    = 0;
  int words_sent    = 0;
  int images_closed = 0;
  int results_seen  = 0;
  int too_long_seen = 0;
  int cfg_writes    = 0;
  int idle_cycles   = 0;
  int send_quiet    = 0;
  bit send_calm     = 1'b0;

  crc32_word_padded_image uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_word   (in_data_word),
    .in_valid_bytes (in_valid_bytes),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_crc_value  (out_crc_value),
    .out_too_long   (out_too_long),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] fold_word(input logic [31:0] crc, input logic [31:0] w);
    logic [31:0] c;
    c = crc ^ w;
    for (int b = 0; b < 32; b++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] fill_missing_bytes(input logic [31:0] d, input logic [2:0] vb);
    logic [31:0] w;
    int          present;
    w = d;
    present = (vb > 3'd4) ? 4 : int'(vb);
    for (int i = 0; i < 4; i++) begin
      if (i >= present) begin
        w[8*i +: 8] = crcw_pkg::FILL_BYTE;
      end
    end
    return w;
  endfunction

  function automatic logic [crcw_pkg::CNT_W-1:0] partition_limit();
    logic [crcw_pkg::CNT_W-1:0] lim;
    if (total_words_cfg > COUNT_MAX) begin
      lim = COUNT_MAX;
    end else begin
      lim = total_words_cfg;
    end
    return lim;
  endfunction

  // Folds a word into the CRC below the limit and queues the result on the last word.
  function automatic void absorb_word(input logic [31:0] d, input logic [2:0] vb,
                                      input logic lst, input logic typed,
                                      input crc_result_t typed_res);
    logic [crcw_pkg::CNT_W-1:0] lim;
    crc_result_t                res;
    lim = partition_limit();
    if (words_folded < lim) begin
      crc_acc = fold_word(crc_acc, fill_missing_bytes(d, vb));
      words_folded = words_folded + 1'b1;
    end else begin
      overflow_flag = 1'b1;
    end
    if (lst) begin
      while (words_folded < lim) begin
        crc_acc = fold_word(crc_acc, crcw_pkg::PAD_WORD);
        words_folded = words_folded + 1'b1;
      end
      res.crc = crc_acc;
      res.too_long = overflow_flag;
      pending_crcs.push_back(typed ? typed_res : res);
      crc_acc = crcw_pkg::CRC_INIT;
      words_folded = '0;
      overflow_flag = 1'b0;
      images_closed++;
    end
  endfunction

  task automatic send_word(input logic [31:0] d, input logic [2:0] vb, input logic lst,
                           input logic typed, input crc_result_t typed_res);
    int gap;
    if (send_quiet == 0) begin
      send_calm = ($urandom_range(0, 3) == 0);
      send_quiet = $urandom_range(8, 40);
    end
    send_quiet--;
    gap = send_calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_word   <= d;
    in_valid_bytes <= vb;
    in_last        <= lst;
    do @(posedge clk); while (!in_ready);
    absorb_word(d, vb, lst, typed, typed_res);
    words_sent++;
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (pending_crcs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_total_words(input logic [crcw_pkg::CFG_W-1:0] v);
    logic [crcw_pkg::APB_DW-1:0] readback;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= TOTAL_WORDS_ADDR;
    cfg_pwdata  <= crcw_pkg::APB_DW'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    total_words_cfg = v;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_psel <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback !== crcw_pkg::APB_DW'(v)) begin
      $error("total_words: expected %h, got %h", crcw_pkg::APB_DW'(v), readback);
      fail_count++;
    end
    cfg_writes++;
  endtask

  initial begin
    int          recv_quiet;
    bit          recv_calm;
    int          stall;
    crc_result_t want;
    recv_quiet = 0;
    recv_calm  = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (recv_quiet == 0) begin
        recv_calm = ($urandom_range(0, 3) == 0);
        recv_quiet = $urandom_range(4, 30);
      end
      recv_quiet--;
      stall = recv_calm ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      results_seen++;
      if (out_too_long) begin
        too_long_seen++;
      end
      if (pending_crcs.size() == 0) begin
        $error("crc_value: no result expected, got %h", out_crc_value);
        fail_count++;
      end else begin
        want = pending_crcs.pop_front();
        if (out_crc_value !== want.crc) begin
          $error("crc_value: expected %h, got %h", want.crc, out_crc_value);
          fail_count++;
        end
        if (out_too_long !== want.too_long) begin
          $error("too_long: expected %b, got %b", want.too_long, out_too_long);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** crc32_word_padded_image: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    crc_result_t                typed_res;
    logic [crcw_pkg::CFG_W-1:0] new_total;
    logic [31:0]                d;
    logic [2:0]                 vb;
    int                         pick;
    int                         phase;
    int                         images;
    int                         fit;
    int                         len;
    int                         largest;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data_word   <= '0;
    in_valid_bytes <= '0;
    in_last        <= 1'b0;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;
    largest = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].kind == ROW_CONFIG) begin
        wait_until_drained();
        write_total_words(SCRIPT[i].value[crcw_pkg::CFG_W-1:0]);
      end else begin
        typed_res.crc = SCRIPT[i].want_crc;
        typed_res.too_long = SCRIPT[i].want_ovf;
        send_word(SCRIPT[i].value, SCRIPT[i].vb, SCRIPT[i].last, SCRIPT[i].typed, typed_res);
      end
    end

    typed_res = '0;
    phase = 0;
    while (words_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (phase == 2) begin
        new_total = crcw_pkg::CFG_W'(BIG_TOTAL);
      end else if (pick == 0) begin
        new_total = '0;
      end else if (pick <= 3) begin
        new_total = crcw_pkg::CFG_W'($urandom_range(SMALL_FIT + 1, 64));
      end else begin
        new_total = crcw_pkg::CFG_W'($urandom_range(1, SMALL_FIT));
      end
      if (int'(new_total) > largest) begin
        largest = int'(new_total);
      end
      wait_until_drained();
      write_total_words(new_total);
      images = $urandom_range(2, 6);
      for (int img = 0; img < images; img++) begin
        fit = (int'(new_total) > SMALL_FIT) ? SMALL_FIT : int'(new_total);
        if (new_total == 0 || $urandom_range(0, 5) == 0) begin
          len = fit + $urandom_range(1, 3);
        end else begin
          len = $urandom_range(1, fit);
        end
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 15) == 0) begin
            d = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h00000000;
          end else begin
            d = $urandom();
          end
          vb = ($urandom_range(0, 3) != 0) ? 3'd4 : 3'($urandom_range(0, 7));
          send_word(d, vb, k == len - 1, 1'b0, typed_res);
        end
        if ($urandom_range(0, 7) == 0) begin
          wait_until_drained();
        end
      end
      phase++;
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words in %0d images over %0d partition sizes, up to %0d words and the maximum.",
             words_sent, images_closed, cfg_writes, largest);
    $display("Checked %0d CRC results, %0d of them flagged as too long.",
             results_seen, too_long_seen);
    if (fail_count == 0) begin
      $display("** crc32_word_padded_image: PASSED **");
    end else begin
      $display("** crc32_word_padded_image: FAILED **");
    end
    $finish;
  end

endmodule
